>>> hdl/sarfr_pkg.sv
// Shared types, register indexes and reset values for the serial ack frame receiver.
`timescale 1ns / 1ps
package sarfr_pkg;

  localparam int MaxFrameDef = 100;

  localparam logic [7:0] StartByteRst    = 8'd75;
  localparam logic [7:0] EndByteRst      = 8'd88;
  localparam logic [7:0] SepByteRst      = 8'd47;
  localparam logic [3:0] RequiredSepsRst = 4'd2;
  localparam logic [2:0] ValueFieldRst   = 3'd1;

  typedef enum logic [2:0] {
    RegStartByte    = 3'd0,
    RegEndByte      = 3'd1,
    RegSepByte      = 3'd2,
    RegRequiredSeps = 3'd3,
    RegValueField   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] sep_byte;
    logic [3:0] required_seps;
    logic [2:0] value_field;
  } cfg_t;

  typedef struct packed {
    logic               frame_ok;
    logic               value_found;
    logic signed [15:0] value;
  } res_t;

endpackage

>>> hdl/serial_ack_frame_receiver_unit.sv
// Top level of the serial ack frame receiver: input register, frame core, result register.
`timescale 1ns / 1ps
// Takes one received byte per transfer and gives one result when a frame closes on the
// end byte: frame_ok when the separator count matched required_seps, and the saturated
// decimal value of the chosen non-empty token. Overlong frames (MaxFrame) end silently.
// A byte is taken every cycle unless the input stalls; its result passes from the input
// register through the update of the frame state into the result register before it is
// offered on the output. Input stalls only while a finished result waits and the output is
// stalled. Configuration writes are always ready and take effect on the next byte.
module serial_ack_frame_receiver_unit #(
  parameter int MaxFrame = sarfr_pkg::MaxFrameDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_ok_o,
  output logic               value_found_o,
  output logic signed [15:0] value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import sarfr_pkg::*;

  cfg_t       cfg;
  res_t       core_res;
  logic       core_res_valid;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  logic       adv, in_xfer, step;

  assign cfg_ready_o = 1'b1;

  sarfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && adv;

  sarfr_core #(
    .MaxFrame (MaxFrame)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = step && core_res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step && core_res_valid) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_ok_o    = out_res_q.frame_ok;
  assign value_found_o = out_res_q.value_found;
  assign value_o       = out_res_q.value;

endmodule

>>> hdl/sarfr_cfg_regs.sv
// Configuration register file of the serial ack frame receiver.
`timescale 1ns / 1ps
module sarfr_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [2:0]        index_i,
  input  logic [7:0]        data_i,
  output sarfr_pkg::cfg_t   cfg_o
);
  import sarfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (index_i)
        RegStartByte:    cfg_d.start_byte    = data_i;
        RegEndByte:      cfg_d.end_byte      = data_i;
        RegSepByte:      cfg_d.sep_byte      = data_i;
        RegRequiredSeps: cfg_d.required_seps = data_i[3:0];
        RegValueField:   cfg_d.value_field   = data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= StartByteRst;
      cfg_q.end_byte      <= EndByteRst;
      cfg_q.sep_byte      <= SepByteRst;
      cfg_q.required_seps <= RequiredSepsRst;
      cfg_q.value_field   <= ValueFieldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/sarfr_core.sv
// Per-byte frame tracker, token splitter and decimal parser.
`timescale 1ns / 1ps
module sarfr_core #(
  parameter int MaxFrame = sarfr_pkg::MaxFrameDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  sarfr_pkg::cfg_t   cfg_i,
  output logic              res_valid_o,
  output sarfr_pkg::res_t   res_o
);
  import sarfr_pkg::*;

  localparam int LenW = $clog2(MaxFrame);

  localparam logic [6:0]  CntMax  = 7'd127;
  localparam logic [7:0]  ChPlus  = 8'd43;
  localparam logic [7:0]  ChMinus = 8'd45;
  localparam logic [7:0]  ChZero  = 8'd48;
  localparam logic [7:0]  ChNine  = 8'd57;
  localparam logic [7:0]  ChSpace = 8'd32;
  localparam logic [7:0]  ChTab   = 8'd9;
  localparam logic [7:0]  ChCr    = 8'd13;
  localparam logic [16:0] AccSat  = 17'd32768;
  localparam logic [16:0] PosMax  = 17'd32767;

  typedef enum logic [2:0] {
    PhLead   = 3'b001,
    PhDigits = 3'b010,
    PhStop   = 3'b100
  } phase_e;

  logic            cap_q, cap_d;
  logic [6:0]      sep_q, sep_d;
  logic [LenW-1:0] len_q, len_d;
  logic [6:0]      tok_q, tok_d;
  logic            in_tok_q, in_tok_d;
  phase_e          ph_q, ph_d;
  logic            neg_q, neg_d;
  logic [16:0]     acc_q, acc_d;

  logic [6:0]      e_sep, e_tok, sep_n, tok_n;
  logic [LenW-1:0] e_len;
  logic            e_in_tok, e_neg;
  phase_e          e_ph;
  logic [16:0]     e_acc;
  logic            is_digit, is_space, do_acc, found;
  logic [19:0]     acc_mul;

  assign e_sep    = cap_q ? sep_q    : '0;
  assign e_tok    = cap_q ? tok_q    : '0;
  assign e_len    = cap_q ? len_q    : '0;
  assign e_in_tok = cap_q ? in_tok_q : 1'b0;
  assign e_neg    = cap_q ? neg_q    : 1'b0;
  assign e_ph     = cap_q ? ph_q     : PhLead;
  assign e_acc    = cap_q ? acc_q    : '0;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_space = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));
  assign acc_mul  = {e_acc, 3'b000} + {2'b00, e_acc, 1'b0}
                  + {12'd0, byte_i - ChZero};

  always_comb begin
    cap_d       = cap_q;
    sep_d       = sep_q;
    len_d       = len_q;
    tok_d       = tok_q;
    in_tok_d    = in_tok_q;
    ph_d        = ph_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    sep_n       = (e_sep != CntMax) ? e_sep + 7'd1 : e_sep;
    tok_n       = e_tok;
    do_acc      = 1'b0;
    found       = e_tok > {4'd0, cfg_i.value_field};
    if (step_i && (cap_q || (byte_i == cfg_i.start_byte))) begin
      if (byte_i == cfg_i.end_byte) begin
        res_valid_o = 1'b1;
        res_o.frame_ok = ((byte_i == cfg_i.sep_byte) ? sep_n : e_sep)
                         == {3'd0, cfg_i.required_seps};
        res_o.value_found = found;
        if (!found) begin
          res_o.value = '0;
        end else if (e_neg) begin
          res_o.value = 16'(17'd0 - e_acc);
        end else begin
          res_o.value = (e_acc > PosMax) ? 16'sh7fff : e_acc[15:0];
        end
        cap_d    = 1'b0;
        sep_d    = '0;
        len_d    = '0;
        tok_d    = '0;
        in_tok_d = 1'b0;
        ph_d     = PhLead;
        neg_d    = 1'b0;
        acc_d    = '0;
      end else if (e_len >= LenW'(MaxFrame - 1)) begin
        cap_d    = 1'b0;
        sep_d    = '0;
        len_d    = '0;
        tok_d    = '0;
        in_tok_d = 1'b0;
        ph_d     = PhLead;
        neg_d    = 1'b0;
        acc_d    = '0;
      end else begin
        cap_d = 1'b1;
        len_d = e_len + 1'b1;
        tok_d = e_tok;
        in_tok_d = e_in_tok;
        ph_d  = e_ph;
        neg_d = e_neg;
        acc_d = e_acc;
        if (byte_i == cfg_i.sep_byte) begin
          sep_d    = sep_n;
          in_tok_d = 1'b0;
        end else begin
          sep_d = e_sep;
          if (!e_in_tok && (e_tok != CntMax)) begin
            tok_n = e_tok + 7'd1;
          end
          tok_d    = tok_n;
          in_tok_d = 1'b1;
          if (tok_n == ({4'd0, cfg_i.value_field} + 7'd1)) begin
            case (e_ph)
              PhLead: begin
                if (is_space) begin
                  ph_d = PhLead;
                end else if (byte_i == ChPlus) begin
                  ph_d = PhDigits;
                end else if (byte_i == ChMinus) begin
                  neg_d = 1'b1;
                  ph_d  = PhDigits;
                end else if (!is_digit) begin
                  ph_d = PhStop;
                end else begin
                  ph_d   = PhDigits;
                  do_acc = 1'b1;
                end
              end
              PhDigits: begin
                if (is_digit) begin
                  do_acc = 1'b1;
                end else begin
                  ph_d = PhStop;
                end
              end
              PhStop: ph_d = PhStop;
              default: ph_d = PhStop;
            endcase
            if (do_acc) begin
              acc_d = (acc_mul > {3'd0, AccSat}) ? AccSat : acc_mul[16:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 1'b0;
      sep_q    <= '0;
      len_q    <= '0;
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      ph_q     <= PhLead;
      neg_q    <= 1'b0;
      acc_q    <= '0;
    end else begin
      cap_q    <= cap_d;
      sep_q    <= sep_d;
      len_q    <= len_d;
      tok_q    <= tok_d;
      in_tok_q <= in_tok_d;
      ph_q     <= ph_d;
      neg_q    <= neg_d;
      acc_q    <= acc_d;
    end
  end

endmodule

>>> hdl/sarfr_checker.sv
// Port-level assertions for the serial ack frame receiver, bound to the top level.
`timescale 1ns / 1ps
module sarfr_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               value_found_o,
  input logic signed [15:0] value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_found_o |-> value_o == 16'sd0)
    else $error("missing token gives nonzero value");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a byte transfer two cycles earlier");

endmodule

bind serial_ack_frame_receiver_unit sarfr_port_checker u_sarfr_port_checker (.*);

>>> tb/sv/sarfr_checker.sv
// Checker for the serial ack frame receiver: predicts acks from byte transfers and compares them.
`timescale 1ns / 1ps
module sarfr_checker
  import sarfr_pkg::*;
#(
  parameter int MaxFrame = MaxFrameDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               frame_ok_i,
  input  logic               value_found_i,
  input  logic signed [15:0] value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 acks_o,
  output int                 acks_ok_o
);

  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] Ch0     = 8'd48;
  localparam logic [7:0] Ch9     = 8'd57;

  typedef enum logic [1:0] {
    PhLead,
    PhDigits,
    PhStopped
  } num_phase_e;

  cfg_t        cfg;
  logic        capturing;
  logic [6:0]  sep_cnt;
  logic [6:0]  frame_len;
  logic [6:0]  tok_cnt;
  logic        in_tok;
  num_phase_e  phase;
  logic        neg;
  logic [16:0] mag;
  res_t        ack_q[$];

  function automatic void clear_frame();
    capturing = 1'b0;
    sep_cnt   = '0;
    frame_len = '0;
    tok_cnt   = '0;
    in_tok    = 1'b0;
    phase     = PhLead;
    neg       = 1'b0;
    mag       = '0;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == ChSpace || (b >= ChTab && b <= ChCr);
  endfunction

  // atoi-style digit accumulation on the selected token
  function automatic void parse_char(input logic [7:0] b);
    logic is_digit;
    int   acc;
    is_digit = b >= Ch0 && b <= Ch9;
    case (phase)
      PhLead: begin
        if (is_ws(b)) return;
        if (b == ChPlus) begin
          phase = PhDigits;
          return;
        end
        if (b == ChMinus) begin
          neg   = 1'b1;
          phase = PhDigits;
          return;
        end
        if (!is_digit) begin
          phase = PhStopped;
          return;
        end
        phase = PhDigits;
      end
      PhDigits: begin
        if (!is_digit) begin
          phase = PhStopped;
          return;
        end
      end
      default: return;
    endcase
    acc = int'(mag) * 10 + int'(b - Ch0);
    mag = (acc > 32768) ? 17'd32768 : 17'(acc);
  endfunction

  function automatic logic predict_ack(input logic [7:0] b, output res_t r);
    logic found;
    r = '0;
    if (!capturing) begin
      if (b != cfg.start_byte) return 1'b0;
      clear_frame();
      capturing = 1'b1;
    end
    if (b == cfg.end_byte) begin
      if (b == cfg.sep_byte && sep_cnt < 7'd127) sep_cnt++;
      found         = tok_cnt > 7'(cfg.value_field);
      r.frame_ok    = sep_cnt == 7'(cfg.required_seps);
      r.value_found = found;
      if (!found) r.value = '0;
      else if (neg) r.value = 16'(17'd0 - mag);
      else r.value = (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
      clear_frame();
      return 1'b1;
    end
    if (int'(frame_len) + 2 > MaxFrame) begin
      clear_frame();
      return 1'b0;
    end
    if (b == cfg.sep_byte) begin
      if (sep_cnt < 7'd127) sep_cnt++;
      in_tok = 1'b0;
    end else begin
      if (!in_tok) begin
        in_tok = 1'b1;
        if (tok_cnt < 7'd127) tok_cnt++;
      end
      if (tok_cnt == 7'(cfg.value_field) + 7'd1) parse_char(b);
    end
    frame_len++;
    return 1'b0;
  endfunction

  task automatic report(input string what, input int want, input int got);
    if (fail_cnt_o < 40) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t nxt;
    if (!rst_ni) begin
      cfg = '{StartByteRst, EndByteRst, SepByteRst, RequiredSepsRst, ValueFieldRst};
      clear_frame();
      ack_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      acks_o     = 0;
      acks_ok_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        acks_o++;
        if (ack_q.size() == 0) begin
          report("ack with none pending", 0, 1);
        end else begin
          want = ack_q.pop_front();
          if (want.frame_ok) acks_ok_o++;
          if (frame_ok_i !== want.frame_ok) report("frame_ok", want.frame_ok, frame_ok_i);
          if (value_found_i !== want.value_found) begin
            report("value_found", want.value_found, value_found_i);
          end
          if (value_i !== want.value) begin
            report("value", $signed(want.value), $signed(value_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (predict_ack(rx_byte_i, nxt)) ack_q.push_back(nxt);
      end
      // register writes apply from the next byte on
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          RegStartByte:    cfg.start_byte    = cfg_data_i;
          RegEndByte:      cfg.end_byte      = cfg_data_i;
          RegSepByte:      cfg.sep_byte      = cfg_data_i;
          RegRequiredSeps: cfg.required_seps = cfg_data_i[3:0];
          RegValueField:   cfg.value_field   = cfg_data_i[2:0];
          default: ;
        endcase
      end
      pending_o = ack_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the serial ack frame receiver: clock, reset, byte frames and verdict.
`timescale 1ns / 1ps
module tb_top;
  import sarfr_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int PhaseBytes   = 200;
  localparam int NumPhases    = 8;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] Ch0     = 8'd48;
  localparam logic [7:0] ChSpace = 8'd32;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               frame_ok;
  logic               value_found;
  logic signed [15:0] value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [7:0]         cfg_data;

  int   fail_cnt;
  int   pending;
  int   acks;
  int   acks_ok;
  int   send_idle_pct;
  int   stall_pct;
  int   cycle_cnt;
  int   sent_bytes;
  int   noise_bytes;
  int   frames_sent;
  cfg_t cur;
  cfg_t settings[NumPhases];

  serial_ack_frame_receiver_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .frame_ok_o    (frame_ok),
    .value_found_o (value_found),
    .value_o       (value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  sarfr_checker #(
    .MaxFrame (MaxFrameDef)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .frame_ok_i    (frame_ok),
    .value_found_i (value_found),
    .value_i       (value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .acks_o        (acks),
    .acks_ok_o     (acks_ok)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAIL serial_ack_frame_receiver_unit");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  // hold off input until every ack is out and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain();
    write_reg(RegStartByte, c.start_byte);
    write_reg(RegEndByte, c.end_byte);
    write_reg(RegSepByte, c.sep_byte);
    write_reg(RegRequiredSeps, 8'(c.required_seps));
    write_reg(RegValueField, 8'(c.value_field));
    cur = c;
  endtask

  function automatic logic [7:0] body_byte(input logic [7:0] b);
    while (b == cur.end_byte || b == cur.sep_byte) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] ws_char();
    return ($urandom_range(5) == 0) ? ChSpace : 8'(8 + $urandom_range(1, 5));
  endfunction

  task automatic send_token();
    int n;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(body_byte(8'($urandom_range(255))));
    end else begin
      repeat ($urandom_range(2)) send_byte(body_byte(ws_char()));
      case ($urandom_range(2))
        1: send_byte(body_byte(ChPlus));
        2: send_byte(body_byte(ChMinus));
        default: ;
      endcase
      n = $urandom_range(6);
      repeat (n) send_byte(body_byte(8'(Ch0 + $urandom_range(9))));
      if ($urandom_range(3) == 0) send_byte(body_byte(8'($urandom_range(255))));
    end
  endtask

  task automatic send_frame();
    int seps;
    int fill;
    bit broken;
    bit overlong;
    logic [7:0] b;
    seps     = $urandom_range(1) ? int'(cur.required_seps) : $urandom_range(15);
    fill     = (seps > 8) ? 45 : 80;
    overlong = $urandom_range(19) == 0;
    broken   = $urandom_range(9) == 0;
    repeat ($urandom_range(2)) begin
      b = 8'($urandom_range(255));
      if (b == cur.start_byte) b = ~b;
      send_byte(b);
      noise_bytes++;
    end
    send_byte(cur.start_byte);
    for (int s = 0; s <= seps; s++) begin
      if (s > 0) send_byte(cur.sep_byte);
      if ($urandom_range(99) < fill) send_token();
    end
    if (overlong) repeat (100) send_byte(body_byte(8'($urandom_range(255))));
    if (!broken) send_byte(cur.end_byte);
    frames_sent++;
  endtask

  initial begin
    string directed;
    int    target;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sent_bytes    = 0;
    noise_bytes   = 0;
    frames_sent   = 0;
    cur = '{StartByteRst, EndByteRst, SepByteRst, RequiredSepsRst, ValueFieldRst};

    settings[0] = cur;
    settings[1] = '{8'h00, 8'hFF, 8'h80, 4'd0, 3'd0};
    settings[2] = '{8'hFF, 8'h00, 8'h7F, 4'd15, 3'd7};
    settings[3] = '{StartByteRst, StartByteRst, SepByteRst, RequiredSepsRst, ValueFieldRst};
    settings[4] = '{StartByteRst, SepByteRst, SepByteRst, 4'd3, 3'd2};
    settings[5] = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    4'($urandom_range(15)), 3'($urandom_range(7))};
    settings[6] = '{8'($urandom_range(255)), 8'($urandom_range(255)), ChSpace,
                    4'($urandom_range(15)), 3'($urandom_range(7))};
    settings[7] = '{StartByteRst, EndByteRst, SepByteRst, RequiredSepsRst, ValueFieldRst};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle extremes, then signs, whitespace, saturation, empty tokens, empty frame
    send_byte(8'h00);
    send_byte(8'hFF);
    directed = "K/ -99999/XKK//+40000XKX";
    for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);
    noise_bytes += 2;

    for (int p = 0; p < NumPhases; p++) begin
      apply_cfg(settings[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      target = sent_bytes - noise_bytes + PhaseBytes;
      while (sent_bytes - noise_bytes < target) send_frame();
    end

    drain();
    repeat (4) @(negedge clk);
    $display("covered %0d frame bytes and %0d idle-noise bytes in %0d frames over %0d settings",
             sent_bytes - noise_bytes, noise_bytes, frames_sent, NumPhases + 1);
    $display("checked %0d acks, %0d with the separator count met", acks, acks_ok);
    if (fail_cnt == 0) begin
      $display("PASS serial_ack_frame_receiver_unit");
    end else begin
      $display("FAIL serial_ack_frame_receiver_unit");
    end
    $finish;
  end

endmodule
